@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define EDHR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Expression must never be true outside reset.
`define EDHR_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

@@ rtl/edhr_pkg.sv @@
`timescale 1ns / 1ps

package edhr_pkg;

  // Default store depths (both powers of two)
  localparam int TABLE_SLOTS_DEF = 16384;
  localparam int POINT_SLOTS_DEF = 65536;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int ID_W     = 16;
  localparam int NUM_W    = 17;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 4;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // Table size register limits and reset value
  localparam logic [CFG_W-1:0] LOG2_MIN   = 4'd4;
  localparam logic [CFG_W-1:0] LOG2_MAX   = 4'd14;
  localparam logic [CFG_W-1:0] LOG2_RESET = 4'd14;

  // Register index (word address bit)
  localparam logic [0:0] REG_TABLE_LOG2 = 1'b0;

  // Fibonacci hash: only bits 32 up to 32+HASH_BITS-1 of the product are used
  localparam int HASH_BITS = 14;
  localparam logic [63:0] FIB_MUL = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [31:0] FIB_LO32 = FIB_MUL[31:0];
  localparam logic [HASH_BITS-1:0] FIB_MID = FIB_MUL[32+HASH_BITS-1:32];
  localparam logic [HASH_BITS-1:0] FIB_LOW = FIB_MUL[HASH_BITS-1:0];

  // Item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_POINT = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_NEW_DRAWN   = 3'd0,
    ST_NEW_CLAIMED = 3'd1,
    ST_DUPLICATE   = 3'd2,
    ST_DEGENERATE  = 3'd3,
    ST_TABLE_FULL  = 3'd4,
    ST_POINT_KNOWN = 3'd5,
    ST_POINT_NEW   = 3'd6,
    ST_CLEARED     = 3'd7
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    sweep_start;
    logic    sweep_en;
    logic    hash_load;
    logic    probe_step;
    logic    slot_write;
    logic    point_check;
    logic    status_load;
    status_t status_code;
    logic    result_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             degenerate;
    logic             draw;
    logic             slot_empty;
    logic             slot_match;
    logic             probe_last;
    logic             point_known;
    logic             sweep_last;
    logic             out_free;
  } dp_status_t;

endpackage

@@ rtl/edhr_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module edhr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/edhr_ctrl.sv @@
`timescale 1ns / 1ps

// Sequencer: one request at a time, sweep after reset and on clear
module edhr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  edhr_pkg::dp_status_t dp_stat,
  output edhr_pkg::dp_cmd_t    dp_cmd
);

  typedef enum logic [9:0] {
    S_INIT      = 10'b00_0000_0001,
    S_IDLE      = 10'b00_0000_0010,
    S_DECODE    = 10'b00_0000_0100,
    S_HASH      = 10'b00_0000_1000,
    S_PROBE_RD  = 10'b00_0001_0000,
    S_PROBE_CMP = 10'b00_0010_0000,
    S_PCHECK    = 10'b00_0100_0000,
    S_CLEAR     = 10'b00_1000_0000,
    S_RESULT    = 10'b01_0000_0000,
    S_SPARE     = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    case (state)
      S_INIT: begin
        dp_cmd.sweep_en = 1'b1;
        if (dp_stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.capture = 1'b1;
          state_next     = S_DECODE;
        end
      end
      S_DECODE: begin
        case (dp_stat.cmd)
          edhr_pkg::CMD_CLEAR: begin
            dp_cmd.sweep_start = 1'b1;
            state_next         = S_CLEAR;
          end
          edhr_pkg::CMD_EDGE: begin
            if (dp_stat.degenerate) begin
              dp_cmd.status_load = 1'b1;
              dp_cmd.status_code = edhr_pkg::ST_DEGENERATE;
              state_next         = S_RESULT;
            end else begin
              state_next = S_HASH;
            end
          end
          edhr_pkg::CMD_POINT: begin
            state_next = S_PCHECK;
          end
          default: begin
            // unused command: no effect, reported as degenerate
            dp_cmd.status_load = 1'b1;
            dp_cmd.status_code = edhr_pkg::ST_DEGENERATE;
            state_next         = S_RESULT;
          end
        endcase
      end
      S_HASH: begin
        dp_cmd.hash_load = 1'b1;
        state_next       = S_PROBE_RD;
      end
      S_PROBE_RD: begin
        state_next = S_PROBE_CMP;
      end
      S_PROBE_CMP: begin
        if (dp_stat.slot_empty) begin
          dp_cmd.slot_write  = 1'b1;
          dp_cmd.status_load = 1'b1;
          dp_cmd.status_code = dp_stat.draw ? edhr_pkg::ST_NEW_DRAWN
                                            : edhr_pkg::ST_NEW_CLAIMED;
          state_next         = S_RESULT;
        end else if (dp_stat.slot_match) begin
          dp_cmd.status_load = 1'b1;
          dp_cmd.status_code = edhr_pkg::ST_DUPLICATE;
          state_next         = S_RESULT;
        end else if (dp_stat.probe_last) begin
          dp_cmd.status_load = 1'b1;
          dp_cmd.status_code = edhr_pkg::ST_TABLE_FULL;
          state_next         = S_RESULT;
        end else begin
          dp_cmd.probe_step = 1'b1;
          state_next        = S_PROBE_RD;
        end
      end
      S_PCHECK: begin
        dp_cmd.point_check = 1'b1;
        dp_cmd.status_load = 1'b1;
        dp_cmd.status_code = dp_stat.point_known ? edhr_pkg::ST_POINT_KNOWN
                                                 : edhr_pkg::ST_POINT_NEW;
        state_next         = S_RESULT;
      end
      S_CLEAR: begin
        dp_cmd.sweep_en = 1'b1;
        if (dp_stat.sweep_last) begin
          dp_cmd.status_load = 1'b1;
          dp_cmd.status_code = edhr_pkg::ST_CLEARED;
          state_next         = S_RESULT;
        end
      end
      S_RESULT: begin
        // wait for the output register to free up
        if (dp_stat.out_free) begin
          dp_cmd.result_load = 1'b1;
          state_next         = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

@@ rtl/edhr_dp.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Datapath: item latch, hash, probe address, both stores, output register
module edhr_dp #(
  parameter int TABLE_SLOTS = edhr_pkg::TABLE_SLOTS_DEF,
  parameter int POINT_SLOTS = edhr_pkg::POINT_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  edhr_pkg::dp_cmd_t             dp_cmd,
  output edhr_pkg::dp_status_t          dp_stat,
  input  logic [edhr_pkg::CFG_W-1:0]    table_log2,
  input  logic [edhr_pkg::CMD_W-1:0]    in_cmd,
  input  logic [edhr_pkg::ID_W-1:0]     in_a,
  input  logic [edhr_pkg::ID_W-1:0]     in_b,
  input  logic                          in_draw,
  input  logic [edhr_pkg::ID_W-1:0]     in_owner,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [edhr_pkg::STATUS_W-1:0] out_status,
  output logic [edhr_pkg::NUM_W-1:0]    out_mapped,
  output logic [edhr_pkg::ID_W-1:0]     out_owner
);

  localparam int TW        = $clog2(TABLE_SLOTS);
  localparam int PW        = $clog2(POINT_SLOTS);
  localparam int TABLE_LOG2 = $clog2(TABLE_SLOTS + 1) - 1;
  localparam int SWEEP_LEN = (TABLE_SLOTS > POINT_SLOTS) ? TABLE_SLOTS : POINT_SLOTS;
  localparam int SW        = $clog2(SWEEP_LEN);
  localparam int HB        = edhr_pkg::HASH_BITS;
  localparam int IW        = edhr_pkg::ID_W;
  localparam int NW        = edhr_pkg::NUM_W;

  // Latched item
  logic [edhr_pkg::CMD_W-1:0] cmd_q;
  logic [IW-1:0]              a_q;
  logic [IW-1:0]              b_q;
  logic                       draw_q;
  logic [IW-1:0]              owner_q;
  logic [NW-1:0]              mapped_q;
  edhr_pkg::status_t          status_q;

  // Control registers
  logic [SW-1:0]              sweep_cnt;
  logic [NW-1:0]              next_num;

  // Probe state
  logic [TW-1:0]              at;
  logic [TW:0]                probe_cnt;

  // Hash partial products
  logic [47:0]                prod_a;
  logic [HB-1:0]              prod_b;
  logic [HB-1:0]              prod_c;
  logic [HB-1:0]              m0;
  logic [HB-1:0]              m1;
  logic [HB-1:0]              m2;
  logic [HB-1:0]              hash;

  logic [IW-1:0]              lo;
  logic [IW-1:0]              hi;
  logic [2*IW-1:0]            compact;

  logic [edhr_pkg::CFG_W-1:0] n_clamp;
  logic [edhr_pkg::CFG_W-1:0] n_eff;
  logic [TW:0]                size_w;
  logic [TW:0]                size_m1;
  logic [TW-1:0]              mask;

  logic [PW-1:0]              idx;

  // Store ports
  logic                       edge_we;
  logic [TW-1:0]              edge_waddr;
  logic [2*IW-1:0]            edge_wdata;
  logic [2*IW-1:0]            edge_rdata;
  logic                       pt_we;
  logic [PW-1:0]              pt_waddr;
  logic [NW:0]                pt_wdata;
  logic [NW:0]                pt_rdata;
  logic                       edge_sweep_we;
  logic                       pt_sweep_we;
  logic                       pt_new;

  // Undirected key, smaller id high
  assign lo      = (a_q < b_q) ? a_q : b_q;
  assign hi      = (a_q < b_q) ? b_q : a_q;
  assign compact = {lo, hi};

  // Slots in use: clamp to 4..14, then to the physical depth
  always_comb begin
    if (table_log2 < edhr_pkg::LOG2_MIN) begin
      n_clamp = edhr_pkg::LOG2_MIN;
    end else if (table_log2 > edhr_pkg::LOG2_MAX) begin
      n_clamp = edhr_pkg::LOG2_MAX;
    end else begin
      n_clamp = table_log2;
    end
    if (int'(n_clamp) > TABLE_LOG2) begin
      n_eff = edhr_pkg::CFG_W'(TABLE_LOG2);
    end else begin
      n_eff = n_clamp;
    end
  end

  assign size_w  = {{TW{1'b0}}, 1'b1} << n_eff;
  assign size_m1 = size_w - {{TW{1'b0}}, 1'b1};
  assign mask    = size_m1[TW-1:0];

  // Bits 32.. of key * FIB_MUL, key = lo << 32 | hi, split into small products
  assign prod_a = 48'(hi) * 48'(edhr_pkg::FIB_LO32);
  assign prod_b = hi[HB-1:0] * edhr_pkg::FIB_MID;
  assign prod_c = lo[HB-1:0] * edhr_pkg::FIB_LOW;
  assign hash   = m0 + m1 + m2;

  always_ff @(posedge clk) begin
    m0 <= prod_a[32+HB-1:32];
    m1 <= prod_b;
    m2 <= prod_c;
  end

  // Item latch, probe address and status code
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_q    <= in_cmd;
      a_q      <= in_a;
      b_q      <= in_b;
      draw_q   <= in_draw;
      owner_q  <= in_owner;
      mapped_q <= '0;
    end else if (dp_cmd.point_check) begin
      mapped_q <= pt_rdata[NW] ? pt_rdata[NW-1:0] : next_num;
    end
    if (dp_cmd.hash_load) begin
      at        <= TW'(hash) & mask;
      probe_cnt <= '0;
    end else if (dp_cmd.probe_step) begin
      at        <= (at + TW'(1)) & mask;
      probe_cnt <= probe_cnt + {{TW{1'b0}}, 1'b1};
    end
    if (dp_cmd.status_load) begin
      status_q <= dp_cmd.status_code;
    end
  end

  // Clearing sweep counter and next compact number
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      next_num  <= '0;
    end else begin
      if (dp_cmd.sweep_start) begin
        sweep_cnt <= '0;
        next_num  <= '0;
      end else if (dp_cmd.sweep_en) begin
        sweep_cnt <= sweep_cnt + SW'(1);
      end
      if (pt_new) begin
        next_num <= next_num + NW'(1);
      end
    end
  end

  // Edge store
  assign edge_sweep_we = dp_cmd.sweep_en
                         && ({1'b0, sweep_cnt} < (SW+1)'(TABLE_SLOTS));
  assign edge_we       = edge_sweep_we || dp_cmd.slot_write;
  assign edge_waddr    = dp_cmd.sweep_en ? sweep_cnt[TW-1:0] : at;
  assign edge_wdata    = dp_cmd.sweep_en ? '0 : compact;

  edhr_ram #(
    .WIDTH (2*IW),
    .DEPTH (TABLE_SLOTS)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (at),
    .rdata (edge_rdata)
  );

  // Point store: valid bit over the compact number
  assign idx         = PW'(a_q);
  assign pt_new      = dp_cmd.point_check && !pt_rdata[NW];
  assign pt_sweep_we = dp_cmd.sweep_en
                       && ({1'b0, sweep_cnt} < (SW+1)'(POINT_SLOTS));
  assign pt_we       = pt_sweep_we || pt_new;
  assign pt_waddr    = dp_cmd.sweep_en ? sweep_cnt[PW-1:0] : idx;
  assign pt_wdata    = dp_cmd.sweep_en ? '0 : {1'b1, next_num};

  edhr_ram #(
    .WIDTH (NW + 1),
    .DEPTH (POINT_SLOTS)
  ) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (idx),
    .rdata (pt_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.result_load) begin
      out_status <= status_q;
      out_mapped <= mapped_q;
      out_owner  <= owner_q;
    end
  end

  // Status to the controller
  always_comb begin
    dp_stat.cmd         = cmd_q;
    dp_stat.degenerate  = (a_q == b_q);
    dp_stat.draw        = draw_q;
    dp_stat.slot_empty  = (edge_rdata == '0);
    dp_stat.slot_match  = (edge_rdata == compact);
    dp_stat.probe_last  = (probe_cnt == size_m1);
    dp_stat.point_known = pt_rdata[NW];
    dp_stat.sweep_last  = (sweep_cnt == SW'(SWEEP_LEN - 1));
    dp_stat.out_free    = !out_valid || out_ready;
  end

  // Checks
  `EDHR_ASSERT(a_slot_was_empty, clk, rst, dp_cmd.slot_write |-> (edge_rdata == '0), "edge written over a used slot")
  `EDHR_ASSERT_NEVER(a_sweep_collide, clk, rst, dp_cmd.sweep_en && (dp_cmd.slot_write || dp_cmd.point_check), "store write during clearing sweep")
  `EDHR_ASSERT_NEVER(a_num_overrun, clk, rst, next_num > POINT_SLOTS, "compact numbers beyond point store depth")

endmodule

@@ rtl/edge_dedup_hash_renumber.sv @@
`timescale 1ns / 1ps

// Edge de-duplication and compact point renumbering. Edge requests (cmd 1) form an
// undirected key from end_a and end_b, hash it by a Fibonacci multiply and probe a
// linear-probing table; point requests (cmd 2) return a compact number given in order
// of first sight; clear requests (cmd 0) empty both stores. One request is worked at a
// time: an edge is settled by one registered read of the edge RAM and one compare per
// slot probed; a point takes one read of the point RAM; a degenerate edge or an unused
// command needs no store read; a clear sweeps max(TABLE_SLOTS, POINT_SLOTS) addresses.
// A result that is not taken holds the sequencer until out_ready. After reset a
// clearing pass over max(TABLE_SLOTS, POINT_SLOTS) addresses (65536 by default) runs
// before the first request is taken; configuration writes are accepted throughout. A
// finished result waits in an output register while the next request is accepted.
// TABLE_SLOTS and POINT_SLOTS must be powers of two.
module edge_dedup_hash_renumber #(
  parameter int TABLE_SLOTS = edhr_pkg::TABLE_SLOTS_DEF,
  parameter int POINT_SLOTS = edhr_pkg::POINT_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [edhr_pkg::ADDR_W-1:0]   paddr,
  input  logic [edhr_pkg::DATA_W-1:0]   pwdata,
  output logic [edhr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [edhr_pkg::CMD_W-1:0]    cmd,
  input  logic [edhr_pkg::ID_W-1:0]     end_a,
  input  logic [edhr_pkg::ID_W-1:0]     end_b,
  input  logic                          draw,
  input  logic [edhr_pkg::ID_W-1:0]     owner,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [edhr_pkg::STATUS_W-1:0] status,
  output logic [edhr_pkg::NUM_W-1:0]    mapped_index,
  output logic [edhr_pkg::ID_W-1:0]     owner_out
);

  logic [edhr_pkg::CFG_W-1:0] table_log2;
  logic                       reg_sel;
  edhr_pkg::dp_cmd_t          dp_cmd;
  edhr_pkg::dp_status_t       dp_stat;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == edhr_pkg::REG_TABLE_LOG2);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_log2 <= edhr_pkg::LOG2_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      table_log2 <= pwdata[edhr_pkg::CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(edhr_pkg::DATA_W - edhr_pkg::CFG_W){1'b0}}, table_log2}
                          : '0;

  edhr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  edhr_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .POINT_SLOTS (POINT_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat),
    .table_log2 (table_log2),
    .in_cmd     (cmd),
    .in_a       (end_a),
    .in_b       (end_b),
    .in_draw    (draw),
    .in_owner   (owner),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_status (status),
    .out_mapped (mapped_index),
    .out_owner  (owner_out)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // Command code with no operation behind it
  localparam logic [edhr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int REPORT_MAX    = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 230;

  // One expected result
  typedef struct {
    edhr_pkg::status_t              st;
    logic [edhr_pkg::NUM_W-1:0]     idx;
    logic [edhr_pkg::ID_W-1:0]      own;
  } outcome_t;

  // Mirror of the edge table and point numbering, plus the queue of results due
  class edge_ledger;
    logic [31:0]                  slots [edhr_pkg::TABLE_SLOTS_DEF];
    bit                           point_seen [edhr_pkg::POINT_SLOTS_DEF];
    logic [edhr_pkg::NUM_W-1:0]   point_num [edhr_pkg::POINT_SLOTS_DEF];
    logic [edhr_pkg::NUM_W-1:0]   next_num;
    logic [14:0]                  stored;
    logic [edhr_pkg::CFG_W-1:0]   size_log2;
    outcome_t                     due[$];
    int                           failures;
    int                           mismatches;

    function new();
      size_log2  = edhr_pkg::LOG2_RESET;
      failures   = 0;
      mismatches = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (slots[i]) slots[i] = '0;
      foreach (point_seen[i]) begin
        point_seen[i] = 1'b0;
        point_num[i]  = '0;
      end
      next_num = '0;
      stored   = '0;
    endfunction

    function void set_size_log2(logic [edhr_pkg::CFG_W-1:0] v);
      size_log2 = v;
    endfunction

    // Slots in use: clamped to the legal range and to the table depth
    function int unsigned span();
      int unsigned n;
      n = 32'(size_log2);
      if (n < 32'(edhr_pkg::LOG2_MIN)) n = 32'(edhr_pkg::LOG2_MIN);
      if (n > 32'(edhr_pkg::LOG2_MAX)) n = 32'(edhr_pkg::LOG2_MAX);
      while (n > 0 && (1 << n) > edhr_pkg::TABLE_SLOTS_DEF) n--;
      return 1 << n;
    endfunction

    // Fibonacci hash, then linear probe with wrap
    function edhr_pkg::status_t insert_edge(logic [edhr_pkg::ID_W-1:0] a,
                                            logic [edhr_pkg::ID_W-1:0] b, logic d);
      logic [edhr_pkg::ID_W-1:0] lo;
      logic [edhr_pkg::ID_W-1:0] hi;
      logic [63:0]               key;
      logic [63:0]               prod;
      logic [31:0]               slot_key;
      int unsigned               size;
      int unsigned               mask;
      int unsigned               at;
      int unsigned               i;
      if (a == b) return edhr_pkg::ST_DEGENERATE;
      lo       = (a < b) ? a : b;
      hi       = (a < b) ? b : a;
      key      = {16'd0, lo, 16'd0, hi};
      prod     = key * edhr_pkg::FIB_MUL;
      slot_key = {lo, hi};
      size     = span();
      mask     = size - 1;
      at       = prod[63:32] & mask;
      for (i = 0; i < size; i++) begin
        if (slots[at] == '0) begin
          slots[at] = slot_key;
          if (stored != 15'h7FFF) stored++;
          return d ? edhr_pkg::ST_NEW_DRAWN : edhr_pkg::ST_NEW_CLAIMED;
        end
        if (slots[at] == slot_key) return edhr_pkg::ST_DUPLICATE;
        at = (at + 1) & mask;
      end
      return edhr_pkg::ST_TABLE_FULL;
    endfunction

    // Accepted request: work out its result and queue it
    function void note_request(logic [edhr_pkg::CMD_W-1:0] c, logic [edhr_pkg::ID_W-1:0] a,
                               logic [edhr_pkg::ID_W-1:0] b, logic d,
                               logic [edhr_pkg::ID_W-1:0] o);
      outcome_t e;
      e.st  = edhr_pkg::ST_DEGENERATE;
      e.idx = '0;
      e.own = o;
      case (c)
        edhr_pkg::CMD_CLEAR: begin
          wipe();
          e.st = edhr_pkg::ST_CLEARED;
        end
        edhr_pkg::CMD_EDGE: e.st = insert_edge(a, b, d);
        edhr_pkg::CMD_POINT: begin
          if (point_seen[a]) begin
            e.st = edhr_pkg::ST_POINT_KNOWN;
          end else begin
            point_seen[a] = 1'b1;
            point_num[a]  = next_num;
            next_num      = next_num + edhr_pkg::NUM_W'(1);
            e.st          = edhr_pkg::ST_POINT_NEW;
          end
          e.idx = point_num[a];
        end
        default: ;
      endcase
      due = {due, e};
    endfunction

    // Accepted result against the oldest one due
    function void check_result(logic [edhr_pkg::STATUS_W-1:0] s,
                               logic [edhr_pkg::NUM_W-1:0] m,
                               logic [edhr_pkg::ID_W-1:0] o);
      outcome_t e;
      if (due.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with none due: status %0d mapped %0d owner %0d",
                   $time, s, m, o);
        return;
      end
      e = due.pop_front();
      if (s !== e.st || m !== e.idx || o !== e.own) begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: mismatch exp/act status %0d/%0d mapped %0d/%0d owner %0d/%0d",
                   $time, e.st, s, e.idx, m, e.own, o);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [edhr_pkg::ADDR_W-1:0]   paddr;
  logic [edhr_pkg::DATA_W-1:0]   pwdata;
  logic [edhr_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_ready;
  logic [edhr_pkg::CMD_W-1:0]    cmd;
  logic [edhr_pkg::ID_W-1:0]     end_a;
  logic [edhr_pkg::ID_W-1:0]     end_b;
  logic                          draw;
  logic [edhr_pkg::ID_W-1:0]     owner;
  logic                          out_valid;
  logic                          out_ready;
  logic [edhr_pkg::STATUS_W-1:0] status;
  logic [edhr_pkg::NUM_W-1:0]    mapped_index;
  logic [edhr_pkg::ID_W-1:0]     owner_out;

  edge_ledger ledger = new();
  bit         quiet;
  bit         hold_req;
  int         clears_left;
  logic [edhr_pkg::ID_W-1:0] pool_base;

  edge_dedup_hash_renumber u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .end_a        (end_a),
    .end_b        (end_b),
    .draw         (draw),
    .owner        (owner),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .mapped_index (mapped_index),
    .owner_out    (owner_out)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) ledger.note_request(cmd, end_a, end_b, draw, owner);
      if (out_valid && out_ready) ledger.check_result(status, mapped_index, owner_out);
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Run limit
  initial begin
    #(40_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // Offer one request after a random gap; returns at the accepting edge
  task automatic send_request(logic [edhr_pkg::CMD_W-1:0] c, logic [edhr_pkg::ID_W-1:0] a,
                              logic [edhr_pkg::ID_W-1:0] b, logic d,
                              logic [edhr_pkg::ID_W-1:0] o);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    end_a    <= a;
    end_b    <= b;
    draw     <= d;
    owner    <= o;
    do @(posedge clk); while (!in_ready);
  endtask

  // Table size register write, upper data bits random
  task automatic write_size_log2(logic [edhr_pkg::CFG_W-1:0] v);
    logic [edhr_pkg::DATA_W-1:0] data;
    data = $urandom();
    data[edhr_pkg::CFG_W-1:0] = v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {edhr_pkg::REG_TABLE_LOG2, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ledger.set_size_log2(v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop offering and wait for every result due
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [edhr_pkg::ID_W-1:0] pool_id(int pool);
    return pool_base + edhr_pkg::ID_W'($urandom_range(0, pool - 1));
  endfunction

  // Mostly edges and points from a small id pool so duplicates and collisions occur
  task automatic run_random(int count, int pool, int hold_at);
    int i;
    int r;
    logic [edhr_pkg::CMD_W-1:0] c;
    logic [edhr_pkg::ID_W-1:0]  a;
    logic [edhr_pkg::ID_W-1:0]  b;
    for (i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      a = edhr_pkg::ID_W'($urandom());
      b = edhr_pkg::ID_W'($urandom());
      if (clears_left > 0 && $urandom_range(0, 299) == 0) begin
        c = edhr_pkg::CMD_CLEAR;
        clears_left--;
      end else if (r < 55) begin
        c = edhr_pkg::CMD_EDGE;
        r = $urandom_range(0, 9);
        if (r < 8) begin
          a = pool_id(pool);
          b = pool_id(pool);
        end else if (r == 8) begin
          b = a;
        end
      end else if (r < 95) begin
        c = edhr_pkg::CMD_POINT;
        if ($urandom_range(0, 3) != 0) a = pool_id(pool);
      end else begin
        c = CMD_UNUSED;
      end
      send_request(c, a, b, 1'($urandom_range(0, 1)), edhr_pkg::ID_W'($urandom()));
    end
  endtask

  initial begin
    int p;
    int phase_log2 [PHASES];
    int phase_pool [PHASES];
    phase_log2 = '{0, 4, 15, 14, 5, 9, 12};
    phase_pool = '{48, 40, 400, 2000, 64, 200, 100};
    phase_log2[PHASES-1] = $urandom_range(0, 15);
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    cmd         = edhr_pkg::CMD_CLEAR;
    end_a       = '0;
    end_b       = '0;
    draw        = 1'b0;
    owner       = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    clears_left = 6;
    pool_base   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_size_log2(edhr_pkg::LOG2_RESET);

    // Directed: every command, id extremes, degenerate and duplicate edges
    send_request(edhr_pkg::CMD_CLEAR, 16'd0, 16'd0, 1'b0, 16'd0);
    send_request(edhr_pkg::CMD_EDGE, 16'd1, 16'd2, 1'b1, 16'd1);
    send_request(edhr_pkg::CMD_EDGE, 16'd2, 16'd1, 1'b0, 16'd2);
    send_request(edhr_pkg::CMD_EDGE, 16'd2, 16'd3, 1'b0, 16'd3);
    send_request(edhr_pkg::CMD_EDGE, 16'd5, 16'd5, 1'b1, 16'd4);
    send_request(edhr_pkg::CMD_EDGE, 16'd0, 16'hFFFF, 1'b1, 16'hFFFF);
    send_request(edhr_pkg::CMD_EDGE, 16'hFFFF, 16'd0, 1'b1, 16'hAAAA);
    send_request(edhr_pkg::CMD_EDGE, 16'd0, 16'd0, 1'b0, 16'h5555);
    send_request(edhr_pkg::CMD_EDGE, 16'hFFFF, 16'hFFFF, 1'b1, 16'd7);
    send_request(edhr_pkg::CMD_EDGE, 16'hFFFF, 16'hFFFE, 1'b0, 16'd8);
    send_request(edhr_pkg::CMD_POINT, 16'd0, 16'hFFFF, 1'b1, 16'd9);
    send_request(edhr_pkg::CMD_POINT, 16'd0, 16'd0, 1'b0, 16'd10);
    send_request(edhr_pkg::CMD_POINT, 16'hFFFF, 16'd0, 1'b0, 16'd11);
    send_request(edhr_pkg::CMD_POINT, 16'hFFFF, 16'hFFFF, 1'b1, 16'd12);
    send_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
    send_request(edhr_pkg::CMD_EDGE, 16'd2, 16'd1, 1'b1, 16'd13);
    wait_drained();

    // Random phases over several table sizes; the table is not cleared on resize
    for (p = 0; p < PHASES; p++) begin
      write_size_log2(edhr_pkg::CFG_W'(phase_log2[p]));
      pool_base = edhr_pkg::ID_W'($urandom());
      quiet     = (p == 3);
      run_random(PHASE_ITEMS, phase_pool[p], (p == 1) ? 60 : -1);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.failures == 0 && ledger.due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
